/* hdl/skr_pkg.sv */
// Shared types and constants for the scalar Kalman residual block.
// Fixed field widths, register reset values, state and register codes.
// No dependencies.
`timescale 1ns / 1ps

package skr_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 16;

    // Estimate / residual are signed Q3.16, covariance unsigned Q2.16
    localparam int EST_W = 20;
    localparam int COV_W = 18;
    localparam int DIV_W = 12;

    localparam logic [COV_W-1:0] COV_MAX = {COV_W{1'b1}};

    localparam logic [COV_W-1:0] Q_RESET   = COV_W'(1442);
    localparam logic [COV_W-1:0] R_RESET   = COV_W'(40436);
    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(1500);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_Q   = 2'd0,
        REG_R   = 2'd1,
        REG_DIV = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZDIV,
        ST_KDIV,
        ST_XMUL,
        ST_PMUL,
        ST_FINISH
    } state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* hdl/skr_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on skr_pkg.
`timescale 1ns / 1ps

module skr_div #(
    parameter int NUM_W = skr_pkg::COV_W + skr_pkg::FRAC_BITS_DEF,
    parameter int DEN_W = skr_pkg::COV_W + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output skr_pkg::unit_stat_t stat,
    output logic [NUM_W-1:0]   quot
);
    import skr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial, diff;
    logic             ge, last;

    // numerator bits shift out of the top of quo_reg, quotient bits in at the bottom
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quo_next = {quo_reg[NUM_W-2:0], ge};
    assign last     = cnt_reg == CNT_W'(NUM_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

/* hdl/skr_mul.sv */
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle. Depends on skr_pkg.
`timescale 1ns / 1ps

module skr_mul #(
    parameter int MC_W = skr_pkg::EST_W + 1,
    parameter int ML_W = skr_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MC_W-1:0]   mcand,
    input  logic [ML_W-1:0]          mlier,
    output skr_pkg::unit_stat_t      stat,
    output logic signed [MC_W+ML_W:0] prod
);
    import skr_pkg::*;

    localparam int CNT_W = $clog2(ML_W);

    logic signed [MC_W:0]   hi_reg, hi_next, addend, sum;
    logic [ML_W-1:0]        lo_reg, lo_next;
    logic signed [MC_W-1:0] mc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg, done_reg;
    logic                   last;

    // partial sum shifts right into lo_reg as the multiplier bits are used up
    assign addend  = lo_reg[0] ? (MC_W+1)'(mc_reg) : '0;
    assign sum     = hi_reg + addend;
    assign hi_next = sum >>> 1;
    assign lo_next = {sum[0], lo_reg[ML_W-1:1]};
    assign last    = cnt_reg == CNT_W'(ML_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= mlier;
            mc_reg <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = $signed({hi_reg, lo_reg});

endmodule

/* hdl/scalar_kalman_residual.sv */
// Scalar Kalman filter on a scaled ADC sample, giving residual and estimate.
// Input channel: sample with in_valid / in_stall; a beat is taken when
// in_valid is high and in_stall low. Output channel: residual and estimate
// with out_valid / out_stall, held steady while stalled.
// Config: APB-style port, Q at 0x0, R at 0x4, divisor at 0x8; pready tied high.
// Write configuration only while the block is idle.
// Each beat runs through one shared serial divider (measurement scaling, then
// gain) and one shared serial multiplier (estimate update, then covariance).
// out_valid rises once both divider passes, both multiplier passes and the finish
// step have run after the accepting edge. One item is in flight at a time;
// in_stall is high while it is, so a new beat is taken only once the last item
// has left the finish step.
// The result sits in an output register, so the next beat may start while it
// waits on out_stall; a finished item waits until that register is free.
// Reset restores the register defaults and clears estimate and covariance.
// Depends on skr_pkg, skr_div, skr_mul.
`timescale 1ns / 1ps

module scalar_kalman_residual #(
    parameter int SAMPLE_BITS = skr_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = skr_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [SAMPLE_BITS-1:0]           sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [skr_pkg::EST_W-1:0] residual,
    output logic signed [skr_pkg::EST_W-1:0] estimate,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [skr_pkg::ADDR_W-1:0]       paddr,
    input  logic [skr_pkg::DATA_W-1:0]       pwdata,
    output logic [skr_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import skr_pkg::*;

    localparam int NUM_W  = ((SAMPLE_BITS > COV_W) ? SAMPLE_BITS : COV_W) + FRAC_BITS;
    localparam int DEN_W  = COV_W + 1;   // covariance sum is wider than the divisor
    localparam int K_W    = FRAC_BITS + 1;
    localparam int MC_W   = EST_W + 1;
    localparam int PROD_W = MC_W + 1 + K_W;
    localparam int ZW     = NUM_W + 2;
    localparam int PN_W   = PROD_W - FRAC_BITS;

    localparam logic [K_W-1:0] ONE_K = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic signed [ZW-1:0]     EST_MAX_Z = ZW'(2**(EST_W-1) - 1);
    localparam logic signed [ZW-1:0]     EST_MIN_Z = ZW'(-(2**(EST_W-1)));
    localparam logic signed [PROD_W:0]   EST_MAX_P = (PROD_W+1)'(2**(EST_W-1) - 1);
    localparam logic signed [PROD_W:0]   EST_MIN_P = (PROD_W+1)'(-(2**(EST_W-1)));
    localparam logic signed [EST_W:0]    EST_MAX_R = (EST_W+1)'(2**(EST_W-1) - 1);
    localparam logic signed [EST_W:0]    EST_MIN_R = (EST_W+1)'(-(2**(EST_W-1)));
    localparam logic signed [EST_W-1:0]  EST_MAX   = EST_W'(2**(EST_W-1) - 1);
    localparam logic signed [EST_W-1:0]  EST_MIN   = EST_W'(-(2**(EST_W-1)));

    // configuration
    logic [COV_W-1:0] q_reg, r_reg;
    logic [DIV_W-1:0] div_reg;
    reg_idx_t         reg_idx;
    logic             cfg_wr;

    // filter state and working values
    state_t                  state_reg, state_next;
    logic signed [EST_W-1:0] est_reg, z_reg;
    logic [COV_W-1:0]        cov_reg, pp_reg;
    logic [K_W-1:0]          k_reg;
    logic                    den_zero_reg;

    // output register
    logic                    out_valid_reg;
    logic signed [EST_W-1:0] residual_reg, estimate_reg;
    logic                    out_free, load_out;

    // unit hookup
    logic                     div_start, mul_start;
    logic [NUM_W-1:0]         div_num, div_quot;
    logic [DEN_W-1:0]         div_den;
    logic signed [MC_W-1:0]   mul_mc;
    logic [K_W-1:0]           mul_ml;
    logic signed [PROD_W-1:0] mul_prod;
    unit_stat_t               div_stat, mul_stat;

    // combinational datapath
    logic [DIV_W-1:0]         div_eff;
    logic [COV_W:0]           pp_sum;
    logic [COV_W-1:0]         pp_sat;
    logic [DEN_W-1:0]         den_sum;
    logic signed [ZW-1:0]     z_wide;
    logic signed [EST_W-1:0]  z_sat;
    logic [K_W-1:0]           k_val;
    logic signed [MC_W-1:0]   innov;
    logic signed [PROD_W-1:0] step;
    logic signed [PROD_W:0]   x_sum;
    logic signed [EST_W-1:0]  x_new;
    logic [PN_W-1:0]          pn_wide;
    logic [COV_W-1:0]         p_new;
    logic signed [EST_W:0]    res_wide;
    logic signed [EST_W-1:0]  res_sat;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg   <= Q_RESET;
            r_reg   <= R_RESET;
            div_reg <= DIV_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_Q:   q_reg   <= pwdata[COV_W-1:0];
                REG_R:   r_reg   <= pwdata[COV_W-1:0];
                REG_DIV: div_reg <= pwdata[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_Q:   prdata = DATA_W'(q_reg);
            REG_R:   prdata = DATA_W'(r_reg);
            REG_DIV: prdata = DATA_W'(div_reg);
            default: prdata = '0;
        endcase
    end

    // ---------------- datapath ----------------
    assign div_eff = (div_reg == '0) ? DIV_W'(1) : div_reg;

    assign pp_sum  = {1'b0, cov_reg} + {1'b0, q_reg};
    assign pp_sat  = pp_sum[COV_W] ? COV_MAX : pp_sum[COV_W-1:0];
    assign den_sum = {1'b0, pp_sat} + {1'b0, r_reg};

    assign z_wide = $signed({2'b00, div_quot}) - $signed(ZW'(ONE_K));
    assign z_sat  = (z_wide > EST_MAX_Z) ? EST_MAX :
                    (z_wide < EST_MIN_Z) ? EST_MIN : z_wide[EST_W-1:0];

    // Pp + R of zero gives zero gain
    assign k_val = den_zero_reg ? '0 : div_quot[K_W-1:0];
    assign innov = MC_W'(z_reg) - MC_W'(est_reg);

    // arithmetic shift is floor division by 2^FRAC_BITS
    assign step  = mul_prod >>> FRAC_BITS;
    assign x_sum = (PROD_W+1)'(step) + (PROD_W+1)'(est_reg);
    assign x_new = (x_sum > EST_MAX_P) ? EST_MAX :
                   (x_sum < EST_MIN_P) ? EST_MIN : x_sum[EST_W-1:0];

    assign pn_wide = mul_prod[PROD_W-1:FRAC_BITS];
    assign p_new   = (pn_wide > PN_W'(COV_MAX)) ? COV_MAX : pn_wide[COV_W-1:0];

    assign res_wide = (EST_W+1)'(z_reg) - (EST_W+1)'(est_reg);
    assign res_sat  = (res_wide > EST_MAX_R) ? EST_MAX :
                      (res_wide < EST_MIN_R) ? EST_MIN : res_wide[EST_W-1:0];

    // ---------------- shared serial units ----------------
    skr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    skr_mul #(
        .MC_W (MC_W),
        .ML_W (K_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mcand (mul_mc),
        .mlier (mul_ml),
        .stat  (mul_stat),
        .prod  (mul_prod)
    );

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid)      state_next = ST_ZDIV;
            ST_ZDIV:   if (div_stat.done) state_next = ST_KDIV;
            ST_KDIV:   if (div_stat.done) state_next = ST_XMUL;
            ST_XMUL:   if (mul_stat.done) state_next = ST_PMUL;
            ST_PMUL:   if (mul_stat.done) state_next = ST_FINISH;
            ST_FINISH: if (out_free)      state_next = ST_IDLE;
            default:                      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        div_start = 1'b0;
        div_num   = NUM_W'({sample, {FRAC_BITS{1'b0}}});
        div_den   = DEN_W'(div_eff);
        mul_start = 1'b0;
        mul_mc    = innov;
        mul_ml    = k_val;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                div_start = in_valid;
            end
            ST_ZDIV:
            begin
                div_start = div_stat.done;
                div_num   = NUM_W'({pp_sat, {FRAC_BITS{1'b0}}});
                div_den   = den_sum;
            end
            ST_KDIV:
            begin
                mul_start = div_stat.done;
            end
            ST_XMUL:
            begin
                mul_start = mul_stat.done;
                mul_mc    = $signed(MC_W'(pp_reg));
                mul_ml    = ONE_K - k_reg;
            end
            ST_PMUL:   ;
            ST_FINISH: load_out = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            est_reg       <= '0;
            cov_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_XMUL && mul_stat.done)
                est_reg <= x_new;
            if (state_reg == ST_PMUL && mul_stat.done)
                cov_reg <= p_new;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ZDIV && div_stat.done)
        begin
            z_reg        <= z_sat;
            pp_reg       <= pp_sat;
            den_zero_reg <= den_sum == '0;
        end
        if (state_reg == ST_KDIV && div_stat.done)
            k_reg <= k_val;
        if (load_out)
        begin
            residual_reg <= res_sat;
            estimate_reg <= est_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign residual  = residual_reg;
    assign estimate  = estimate_reg;

    // ---------------- checks ----------------
    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_stat.busy && mul_stat.busy))
        else $error("divider and multiplier busy together");

    a_accept_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!div_stat.busy && !mul_stat.busy))
        else $error("beat accepted while a unit is running");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_XMUL || state_reg == ST_PMUL) |-> (k_reg <= ONE_K))
        else $error("gain above one");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finish step");

endmodule
